// ===== design/svalloc_pkg.sv =====
// Shared constants, codes and types of the synth voice allocator.
// No dependencies; every other design file imports this package.
package svalloc_pkg;

   // Field widths fixed by the external format
   localparam int VOICE_W    = 4;
   localparam int NOTE_W     = 8;
   localparam int CMD_NOTE_W = 7;
   localparam int VEL_W      = 7;
   localparam int AGE_IN_W   = 16;
   localparam int CFG_W      = 5;

   // Largest number of voices the scan can cover
   localparam int MAX_SCAN = 16;

   // Default build parameters
   localparam int NUM_VOICES_DEF = 16;
   localparam int AGE_BITS_DEF   = 16;

   // Reset contents of a status entry
   localparam logic [NOTE_W-1:0] NO_NOTE = 8'd128;

   // Operation codes of an input transaction
   localparam logic OP_REPORT = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // Controller to status table control group
   typedef struct packed {
      logic               rd_en;
      logic [VOICE_W-1:0] rd_idx;
      logic               wr_en;
      logic [VOICE_W-1:0] wr_idx;
      logic [NOTE_W-1:0]  wr_note;
      logic               wr_ended;
   } tbl_ctl_type;

endpackage

// ===== design/svalloc_if.sv =====
// Channel interfaces of the synth voice allocator: request, response and
// register write channels. Depends on svalloc_pkg.
interface svalloc_req_if
   import svalloc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [VOICE_W-1:0]  voice_index;
   logic [NOTE_W-1:0]   note;
   logic [VEL_W-1:0]    velocity;
   logic                voice_ended;
   logic [AGE_IN_W-1:0] voice_age;

   modport source (output valid, operation, voice_index, note, velocity, voice_ended,
                   voice_age, input ready);
   modport sink   (input valid, operation, voice_index, note, velocity, voice_ended,
                   voice_age, output ready);
endinterface

interface svalloc_rsp_if
   import svalloc_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [VOICE_W-1:0]    voice;
   logic [CMD_NOTE_W-1:0] cmd_note;
   logic [VEL_W-1:0]      cmd_velocity;
   logic                  last;

   modport source (output valid, voice, cmd_note, cmd_velocity, last, input ready);
   modport sink   (input valid, voice, cmd_note, cmd_velocity, last, output ready);
endinterface

interface svalloc_csr_if
   import svalloc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== design/svalloc_table.sv =====
// Voice status table: one synchronous memory with one read and one write port
// and a valid bit per entry. Depends on svalloc_pkg.
module svalloc_table
   import svalloc_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF,
   parameter int AGE_BITS   = AGE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tbl_ctl_type         ctl,
   input  logic [AGE_BITS-1:0] wr_age,
   output logic [NOTE_W-1:0]   rd_note,
   output logic                rd_ended,
   output logic [AGE_BITS-1:0] rd_age
);

   localparam int MEM_AW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int ENTRY_W = NOTE_W + 1 + AGE_BITS;

   logic [ENTRY_W-1:0]    mem [NUM_VOICES];
   logic [NUM_VOICES-1:0] vld_ff;
   logic [ENTRY_W-1:0]    rd_word_ff;
   logic                  rd_vld_ff;
   logic [7:0]            rd_ext;
   logic [7:0]            wr_ext;
   logic [MEM_AW-1:0]     rd_addr;
   logic [MEM_AW-1:0]     wr_addr;

   // Map voice numbers onto memory addresses
   assign rd_ext  = 8'(ctl.rd_idx);
   assign wr_ext  = 8'(ctl.wr_idx);
   assign rd_addr = rd_ext[MEM_AW-1:0];
   assign wr_addr = wr_ext[MEM_AW-1:0];

   // Write and read the status memory
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= {ctl.wr_note, ctl.wr_ended, wr_age};
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // Track written entries; a fresh entry reads as a free voice
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // Substitute reset contents for entries never written
   always_comb begin
      if (rd_vld_ff) begin
         rd_note  = rd_word_ff[ENTRY_W-1 -: NOTE_W];
         rd_ended = rd_word_ff[AGE_BITS];
         rd_age   = rd_word_ff[AGE_BITS-1:0];
      end else begin
         rd_note  = NO_NOTE;
         rd_ended = 1'b1;
         rd_age   = '0;
      end
   end

endmodule

// ===== design/svalloc_ctrl.sv =====
// Allocation sequencer: scans the status table one entry per cycle, bar note-off
// stalls, picks or frees voices, owns the rsp register. Depends on svalloc_pkg.
module svalloc_ctrl
   import svalloc_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF,
   parameter int AGE_BITS   = AGE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   svalloc_req_if.sink         req,
   svalloc_rsp_if.source       rsp,
   input  logic [CFG_W-1:0]    voices_in_use,
   output tbl_ctl_type         tbl_ctl,
   output logic [AGE_BITS-1:0] wr_age,
   input  logic [NOTE_W-1:0]   rd_note,
   input  logic                rd_ended,
   input  logic [AGE_BITS-1:0] rd_age
);

   state_type             state_ff, state_in;
   logic [CMD_NOTE_W-1:0] note_ff, note_in;
   logic [VEL_W-1:0]      vel_ff, vel_in;
   logic [VOICE_W-1:0]    eval_idx_ff, eval_idx_in;
   logic [VOICE_W-1:0]    chosen_ff, chosen_in;
   logic [AGE_BITS-1:0]   oldest_ff, oldest_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [VOICE_W-1:0]    pend_voice_ff, pend_voice_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VOICE_W-1:0]    rsp_voice_ff, rsp_voice_in;
   logic [VEL_W-1:0]      rsp_vel_ff, rsp_vel_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [CMD_NOTE_W-1:0] rsp_note_ff;
   logic                  rsp_load;

   logic                  accept;
   logic                  slot_free;
   logic                  note_match;
   logic                  scan_last;
   logic [31:0]           age_ext;

   assign req.ready    = (state_ff == ST_IDLE);
   assign accept       = req.valid && req.ready;
   assign slot_free    = !rsp_valid_ff || rsp.ready;
   assign note_match   = (rd_note == {1'b0, note_ff});
   assign scan_last    = ({1'b0, eval_idx_ff} == (voices_in_use - 5'd1));
   assign age_ext      = 32'(req.voice_age);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.voice        = rsp_voice_ff;
   assign rsp.cmd_note     = rsp_note_ff;
   assign rsp.cmd_velocity = rsp_vel_ff;
   assign rsp.last         = rsp_last_ff;

   // Sequence reports, scans and commands
   always_comb begin
      state_in      = state_ff;
      note_in       = note_ff;
      vel_in        = vel_ff;
      eval_idx_in   = eval_idx_ff;
      chosen_in     = chosen_ff;
      oldest_in     = oldest_ff;
      pend_valid_in = pend_valid_ff;
      pend_voice_in = pend_voice_ff;
      tbl_ctl       = '0;
      wr_age        = '0;
      rsp_load      = 1'b0;
      rsp_voice_in  = rsp_voice_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.operation == OP_REPORT) begin
                  // Store the reported status of an existing voice
                  if (32'(req.voice_index) < 32'(NUM_VOICES)) begin
                     tbl_ctl.wr_en    = 1'b1;
                     tbl_ctl.wr_idx   = req.voice_index;
                     tbl_ctl.wr_note  = req.note;
                     tbl_ctl.wr_ended = req.voice_ended;
                     wr_age           = age_ext[AGE_BITS-1:0];
                  end
               end else if (!req.note[NOTE_W-1]) begin
                  // Start the scan at voice zero
                  note_in        = req.note[CMD_NOTE_W-1:0];
                  vel_in         = req.velocity;
                  eval_idx_in    = '0;
                  chosen_in      = '0;
                  oldest_in      = '0;
                  pend_valid_in  = 1'b0;
                  tbl_ctl.rd_en  = 1'b1;
                  tbl_ctl.rd_idx = '0;
                  state_in       = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (vel_ff != '0) begin
               // Note-on: first reusable voice wins, else track the oldest
               if (note_match || rd_ended) begin
                  chosen_in = eval_idx_ff;
                  state_in  = ST_FINISH;
               end else begin
                  if (rd_age > oldest_ff) begin
                     oldest_in = rd_age;
                     chosen_in = eval_idx_ff;
                  end
                  if (scan_last) begin
                     state_in = ST_FINISH;
                  end else begin
                     eval_idx_in    = eval_idx_ff + 4'd1;
                     tbl_ctl.rd_en  = 1'b1;
                     tbl_ctl.rd_idx = eval_idx_ff + 4'd1;
                  end
               end
            end else if (!(note_match && pend_valid_ff && !slot_free)) begin
               // Note-off: hold one match back so the final one carries last
               if (note_match) begin
                  if (pend_valid_ff) begin
                     rsp_load     = 1'b1;
                     rsp_voice_in = pend_voice_ff;
                     rsp_vel_in   = '0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_voice_in = eval_idx_ff;
               end
               if (scan_last) begin
                  state_in = ST_FINISH;
               end else begin
                  eval_idx_in    = eval_idx_ff + 4'd1;
                  tbl_ctl.rd_en  = 1'b1;
                  tbl_ctl.rd_idx = eval_idx_ff + 4'd1;
               end
            end
         end

         ST_FINISH: begin
            if (vel_ff != '0) begin
               // Emit the assignment and claim the entry
               if (slot_free) begin
                  rsp_load         = 1'b1;
                  rsp_voice_in     = chosen_ff;
                  rsp_vel_in       = vel_ff;
                  rsp_last_in      = 1'b1;
                  tbl_ctl.wr_en    = 1'b1;
                  tbl_ctl.wr_idx   = chosen_ff;
                  tbl_ctl.wr_note  = {1'b0, note_ff};
                  tbl_ctl.wr_ended = 1'b0;
                  wr_age           = '0;
                  state_in         = ST_IDLE;
               end
            end else if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               // Flush the held note-off as the final command
               rsp_load      = 1'b1;
               rsp_voice_in  = pend_voice_ff;
               rsp_vel_in    = '0;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      note_ff       <= note_in;
      vel_ff        <= vel_in;
      eval_idx_ff   <= eval_idx_in;
      chosen_ff     <= chosen_in;
      oldest_ff     <= oldest_in;
      pend_voice_ff <= pend_voice_in;
      if (rsp_load) begin
         rsp_voice_ff <= rsp_voice_in;
         rsp_note_ff  <= note_ff;
         rsp_vel_ff   <= rsp_vel_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // No note-off is held back once the controller is idle
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held note-off left over in idle");

   // The table is never written in the middle of a scan
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      tbl_ctl.wr_en |-> state_ff != ST_SCAN)
      else $error("table write during scan");

   // Only note-off scans send commands before the scan ends
   a_scan_emit_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && rsp_load) |-> (vel_ff == '0 && !rsp_last_in))
      else $error("unexpected command during scan");

   // The final command of a transaction returns the controller to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> state_ff == ST_IDLE)
      else $error("final command without return to idle");

endmodule

// ===== design/synth_voice_allocator_top.sv =====
// Synth voice allocator top level: voice count register, status table and
// allocation sequencer. Depends on svalloc_pkg, svalloc_if, svalloc_table
// and svalloc_ctrl.
//
// Usage:
//  - req carries note events (operation 0) and voice status reports
//    (operation 1). A report is stored in the accept cycle and sends nothing.
//  - A note-on sends one command on rsp with last set. A note-off sends one
//    note-off per scanned voice holding the note, the final one with last
//    set, or nothing when no voice holds it. Events with note above 127
//    are dropped.
//  - csr writes the number of scanned voices; out-of-range values are
//    dropped. Write it only while no event is in progress.
//  - The status memory's single read port visits one voice per cycle, except
//    while a note-off scan waits for the output register; a note-on scan
//    stops at the first free or same-note voice. req is ready again the
//    cycle after the final command is loaded.
//  - A stalled rsp holds its command; a note-off scan pauses at the next
//    match until the output register drains.
//  - Reset empties the table (all voices free, no note, age zero) and sets
//    the voice count to one.
module synth_voice_allocator_top
   import svalloc_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF,
   parameter int AGE_BITS   = AGE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   svalloc_req_if.sink   req,
   svalloc_rsp_if.source rsp,
   svalloc_csr_if.sink   csr
);

   logic [CFG_W-1:0]    voices_ff;
   logic                cfg_ok;
   tbl_ctl_type         tbl_ctl;
   logic [AGE_BITS-1:0] wr_age;
   logic [NOTE_W-1:0]   rd_note;
   logic                rd_ended;
   logic [AGE_BITS-1:0] rd_age;

   // Accept register writes at any time; keep only valid voice counts
   assign csr.ready = 1'b1;
   assign cfg_ok    = (csr.data != '0) && (32'(csr.data) <= 32'(MAX_SCAN))
                      && (32'(csr.data) <= 32'(NUM_VOICES));

   always_ff @(posedge clock) begin
      if (reset) begin
         voices_ff <= 5'd1;
      end else if (csr.valid && csr.ready && cfg_ok) begin
         voices_ff <= csr.data;
      end
   end

   svalloc_table #(
      .NUM_VOICES (NUM_VOICES),
      .AGE_BITS   (AGE_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .wr_age   (wr_age),
      .rd_note  (rd_note),
      .rd_ended (rd_ended),
      .rd_age   (rd_age)
   );

   svalloc_ctrl #(
      .NUM_VOICES (NUM_VOICES),
      .AGE_BITS   (AGE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .voices_in_use (voices_ff),
      .tbl_ctl       (tbl_ctl),
      .wr_age        (wr_age),
      .rd_note       (rd_note),
      .rd_ended      (rd_ended),
      .rd_age        (rd_age)
   );

endmodule

// ===== test/tb_top.sv =====
// Testbench for synth_voice_allocator_top: directed table, then random phases with idling.
// Depends on svalloc_pkg, the svalloc_*_if interfaces and the allocator RTL.
`timescale 1ns / 100ps

module tb_top;
   import svalloc_pkg::*;

   localparam logic OP_NOTE      = 1'b0;
   localparam int   SETTLE_CYCLES = 24;   // covers a full sixteen-voice scan, plus margin
   localparam int   LONG_HOLD     = 300;
   localparam int   SHOW_LIMIT    = 10;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum {ROW_REQ, ROW_CSR} row_kind_type;
   typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_type;

   typedef struct {
      logic                operation;
      logic [VOICE_W-1:0]  voice_index;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    velocity;
      logic                voice_ended;
      logic [AGE_IN_W-1:0] voice_age;
   } note_req_type;

   typedef struct packed {
      logic [VOICE_W-1:0]    voice;
      logic [CMD_NOTE_W-1:0] cmd_note;
      logic [VEL_W-1:0]      cmd_velocity;
      logic                  last;
   } voice_cmd_type;

   typedef struct {
      row_kind_type     kind;
      note_req_type     req;
      logic [CFG_W-1:0] csr_data;
      chk_type          chk;
      voice_cmd_type    typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   svalloc_req_if req_ch ();
   svalloc_rsp_if rsp_ch ();
   svalloc_csr_if csr_ch ();

   synth_voice_allocator_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Shadow of the status table and the voice count
   logic [NOTE_W-1:0]       tbl_note  [NUM_VOICES_DEF];
   logic                    tbl_ended [NUM_VOICES_DEF];
   logic [AGE_BITS_DEF-1:0] tbl_age   [NUM_VOICES_DEF];
   logic [CFG_W-1:0]        voice_count;

   voice_cmd_type voice_cmds_due[$];
   idle_mode_type idle_mode = IDLE_NONE;
   int            hold_left = 0;
   int            fail_count = 0;
   int            shown = 0;
   int            n_reqs = 0;
   int            n_cmds = 0;
   int            n_offs = 0;
   int            n_steals = 0;
   int            n_settings = 0;

   // Clock: 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("FAIL synth_voice_allocator_top");
      $finish;
   end

   // Work out the voice commands caused by one transaction and update the shadow table
   task automatic predict_cmds(input note_req_type it, output voice_cmd_type cmds[$]);
      int            pick;
      bit            free_found;
      logic [AGE_BITS_DEF-1:0] oldest;
      voice_cmd_type cmd;
      cmds = {};
      if (it.operation == OP_REPORT) begin
         tbl_note[it.voice_index]  = it.note;
         tbl_ended[it.voice_index] = it.voice_ended;
         tbl_age[it.voice_index]   = it.voice_age[AGE_BITS_DEF-1:0];
         return;
      end
      if (it.note > 8'd127) return;
      if (it.velocity == '0) begin
         // note-off: one command per scanned voice holding the note
         for (int i = 0; i < voice_count && i < NUM_VOICES_DEF; i++) begin
            if (tbl_note[i] == it.note) begin
               cmd.voice        = VOICE_W'(i);
               cmd.cmd_note     = it.note[CMD_NOTE_W-1:0];
               cmd.cmd_velocity = '0;
               cmd.last         = 1'b0;
               cmds.push_back(cmd);
            end
         end
         if (cmds.size() != 0) cmds[cmds.size()-1].last = 1'b1;
         n_offs += cmds.size();
         return;
      end
      // note-on: first free or same-note voice, else the strictly oldest one
      pick       = 0;
      oldest     = '0;
      free_found = 1'b0;
      for (int i = 0; i < voice_count && i < NUM_VOICES_DEF; i++) begin
         if (tbl_note[i] == it.note || tbl_ended[i]) begin
            pick       = i;
            free_found = 1'b1;
            break;
         end
         if (tbl_age[i] > oldest) begin
            oldest = tbl_age[i];
            pick   = i;
         end
      end
      if (!free_found) n_steals++;
      tbl_note[pick]   = it.note;
      tbl_ended[pick]  = 1'b0;
      tbl_age[pick]    = '0;
      cmd.voice        = VOICE_W'(pick);
      cmd.cmd_note     = it.note[CMD_NOTE_W-1:0];
      cmd.cmd_velocity = it.velocity;
      cmd.last         = 1'b1;
      cmds.push_back(cmd);
   endtask

   // Offer one request transaction, idling first as the mode asks
   task automatic send_req(input note_req_type it, input chk_type chk,
                           input voice_cmd_type typed);
      voice_cmd_type cmds[$];
      int unsigned   gap_pct;
      gap_pct = (idle_mode == IDLE_SEND) ? 70 : (idle_mode == IDLE_BOTH) ? 6 : 0;
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= it.operation;
      req_ch.voice_index <= it.voice_index;
      req_ch.note        <= it.note;
      req_ch.velocity    <= it.velocity;
      req_ch.voice_ended <= it.voice_ended;
      req_ch.voice_age   <= it.voice_age;
      do @(posedge clock); while (!req_ch.ready);
      n_reqs++;
      predict_cmds(it, cmds);
      case (chk)
         CHK_MODEL: voice_cmds_due = {voice_cmds_due, cmds};
         CHK_TYPED: voice_cmds_due.push_back(typed);
         default:   ;
      endcase
   endtask

   // Drop valid and hold until every expected command has come back
   task automatic wait_drained(input bit settle);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (voice_cmds_due.size() != 0) @(posedge clock);
      // a note-off with no match may still be scanning
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the voice count register while the block is idle
   task automatic write_voice_count(input logic [CFG_W-1:0] data);
      wait_drained(1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (data >= 1 && data <= MAX_SCAN && data <= NUM_VOICES_DEF) begin
         voice_count = data;
         n_settings++;
      end
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic stim_row_type row_req(input logic op, input int idx, input int note,
                                            input int vel, input logic ended, input int age,
                                            input chk_type chk, input voice_cmd_type typed);
      stim_row_type r;
      r.kind            = ROW_REQ;
      r.req.operation   = op;
      r.req.voice_index = VOICE_W'(idx);
      r.req.note        = NOTE_W'(note);
      r.req.velocity    = VEL_W'(vel);
      r.req.voice_ended = ended;
      r.req.voice_age   = AGE_IN_W'(age);
      r.csr_data        = '0;
      r.chk             = chk;
      r.typed           = typed;
      return r;
   endfunction

   function automatic stim_row_type row_csr(input int data);
      stim_row_type r;
      r          = row_req(OP_NOTE, 0, 0, 0, 1'b0, 0, CHK_NONE, '0);
      r.kind     = ROW_CSR;
      r.csr_data = CFG_W'(data);
      return r;
   endfunction

   // Random request: mostly reports and note events over a small pool of notes
   function automatic note_req_type rand_req();
      note_req_type it;
      it.operation   = ($urandom_range(99) < 35) ? OP_REPORT : OP_NOTE;
      it.voice_index = VOICE_W'($urandom_range(NUM_VOICES_DEF - 1));
      case ($urandom_range(19))
         0, 1:    it.note = NO_NOTE;
         2, 3:    it.note = NOTE_W'($urandom_range(128));
         default: it.note = NOTE_W'(48 + $urandom_range(23));
      endcase
      it.velocity    = ($urandom_range(99) < 30) ? '0 : VEL_W'($urandom_range(1, 127));
      it.voice_ended = ($urandom_range(99) < 35);
      case ($urandom_range(3))
         0:       it.voice_age = '0;
         1:       it.voice_age = AGE_IN_W'($urandom_range(3));
         2:       it.voice_age = '1;
         default: it.voice_age = AGE_IN_W'($urandom_range(65535));
      endcase
      return it;
   endfunction

   // One random phase; pause once midway until all commands are back
   task automatic run_phase(input idle_mode_type mode, input int count, input bit long_hold);
      idle_mode = mode;
      if (long_hold) hold_left = LONG_HOLD;
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) wait_drained(1'b0);
         send_req(rand_req(), CHK_MODEL, '0);
      end
   endtask

   // Response side: long hold-off first, otherwise stall as the mode asks
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (idle_mode == IDLE_RECV) begin
         rsp_ch.ready <= ($urandom_range(99) >= 70);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_ch.ready <= ($urandom_range(99) >= 6);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Check each command transaction against the oldest expectation
   always @(posedge clock) begin
      voice_cmd_type got;
      voice_cmd_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.voice        = rsp_ch.voice;
         got.cmd_note     = rsp_ch.cmd_note;
         got.cmd_velocity = rsp_ch.cmd_velocity;
         got.last         = rsp_ch.last;
         n_cmds++;
         if (voice_cmds_due.size() == 0) begin
            fail_count++;
            if (shown < SHOW_LIMIT) begin
               shown++;
               $display("%0t: unexpected command voice %0d note %0d vel %0d last %0b",
                        $realtime, got.voice, got.cmd_note, got.cmd_velocity, got.last);
            end
         end else begin
            want = voice_cmds_due.pop_front();
            if (got.voice !== want.voice || got.cmd_note !== want.cmd_note ||
                got.cmd_velocity !== want.cmd_velocity || got.last !== want.last) begin
               fail_count++;
               if (shown < SHOW_LIMIT) begin
                  shown++;
                  $display("%0t: command mismatch: expected voice %0d note %0d vel %0d last %0b",
                           $realtime, want.voice, want.cmd_note, want.cmd_velocity, want.last);
                  $display("%0t:                   actual voice %0d note %0d vel %0d last %0b",
                           $realtime, got.voice, got.cmd_note, got.cmd_velocity, got.last);
               end
            end
         end
      end
   end

   // Main sequence
   initial begin
      stim_row_type rows[$];

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_NOTE;
      req_ch.voice_index = '0;
      req_ch.note        = '0;
      req_ch.velocity    = '0;
      req_ch.voice_ended = 1'b0;
      req_ch.voice_age   = '0;
      rsp_ch.ready       = 1'b1;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      for (int i = 0; i < NUM_VOICES_DEF; i++) begin
         tbl_note[i]  = NO_NOTE;
         tbl_ended[i] = 1'b1;
         tbl_age[i]   = '0;
      end
      voice_count = CFG_W'(1);

      // Directed table: one voice after reset, then two, then sixteen
      rows.push_back(row_req(OP_NOTE, 0, 60, 100, 0, 0, CHK_TYPED,
                             voice_cmd_type'{4'd0, 7'd60, 7'd100, 1'b1}));
      rows.push_back(row_req(OP_NOTE, 0, 61, 127, 0, 0, CHK_TYPED,
                             voice_cmd_type'{4'd0, 7'd61, 7'd127, 1'b1}));
      rows.push_back(row_req(OP_NOTE, 0, 61, 0, 0, 0, CHK_TYPED,
                             voice_cmd_type'{4'd0, 7'd61, 7'd0, 1'b1}));
      rows.push_back(row_req(OP_NOTE, 0, 62, 0, 0, 0, CHK_NONE, '0));        // note-off, no holder
      rows.push_back(row_req(OP_NOTE, 0, 128, 5, 0, 0, CHK_NONE, '0));       // note out of range
      rows.push_back(row_req(OP_NOTE, 0, 128, 0, 1, 65535, CHK_NONE, '0));
      rows.push_back(row_csr(0));                                           // ignored
      rows.push_back(row_csr(2));
      rows.push_back(row_req(OP_REPORT, 0, 10, 0, 0, 5, CHK_NONE, '0));
      rows.push_back(row_req(OP_REPORT, 1, 11, 0, 0, 5, CHK_NONE, '0));
      rows.push_back(row_req(OP_NOTE, 0, 12, 64, 0, 0, CHK_MODEL, '0));      // age tie
      rows.push_back(row_req(OP_REPORT, 1, 11, 0, 0, 0, CHK_NONE, '0));
      rows.push_back(row_req(OP_NOTE, 0, 13, 1, 0, 0, CHK_MODEL, '0));       // all ages zero
      rows.push_back(row_req(OP_REPORT, 1, 11, 0, 0, 65535, CHK_NONE, '0));
      rows.push_back(row_req(OP_NOTE, 0, 14, 33, 0, 0, CHK_MODEL, '0));      // oldest steal
      rows.push_back(row_req(OP_REPORT, 0, 20, 0, 1, 7, CHK_NONE, '0));
      rows.push_back(row_req(OP_REPORT, 1, 20, 0, 0, 9, CHK_NONE, '0));
      rows.push_back(row_req(OP_NOTE, 0, 20, 0, 0, 0, CHK_MODEL, '0));       // two note-offs
      rows.push_back(row_req(OP_NOTE, 0, 20, 90, 0, 0, CHK_MODEL, '0));      // same note
      rows.push_back(row_csr(17));                                          // ignored
      rows.push_back(row_csr(31));                                          // ignored
      rows.push_back(row_csr(16));
      rows.push_back(row_req(OP_REPORT, 15, 0, 127, 0, 65535, CHK_NONE, '0));
      rows.push_back(row_req(OP_NOTE, 0, 0, 127, 0, 0, CHK_MODEL, '0));
      rows.push_back(row_req(OP_NOTE, 0, 0, 0, 0, 0, CHK_MODEL, '0));
      rows.push_back(row_req(OP_REPORT, 7, 128, 0, 1, 65535, CHK_NONE, '0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table without idling
      foreach (rows[r]) begin
         if (rows[r].kind == ROW_CSR) write_voice_count(rows[r].csr_data);
         else                         send_req(rows[r].req, rows[r].chk, rows[r].typed);
      end

      // Random phases over several voice counts
      run_phase(IDLE_NONE, 70, 1'b0);
      write_voice_count(CFG_W'(1));
      run_phase(IDLE_SEND, 50, 1'b0);
      write_voice_count(CFG_W'($urandom_range(2, 15)));
      run_phase(IDLE_RECV, 70, 1'b1);
      write_voice_count(CFG_W'($urandom_range(17, 31)));
      write_voice_count(CFG_W'(16));
      run_phase(IDLE_BOTH, 70, 1'b0);

      wait_drained(1'b1);
      if (voice_cmds_due.size() != 0) begin
         fail_count += voice_cmds_due.size();
         $display("%0d expected voice commands never arrived", voice_cmds_due.size());
      end

      $display("Sent %0d requests over %0d voice-count settings; checked %0d commands",
               n_reqs, n_settings, n_cmds);
      $display("  including %0d note-offs and %0d oldest-voice steals; %0d errors",
               n_offs, n_steals, fail_count);
      if (fail_count == 0) begin
         $display("PASS synth_voice_allocator_top");
      end else begin
         $display("FAIL synth_voice_allocator_top");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/svalloc_pkg.sv
design/svalloc_if.sv
design/svalloc_table.sv
design/svalloc_ctrl.sv
design/synth_voice_allocator_top.sv
test/tb_top.sv
